### src/ptee_pkg.sv
package ptee_pkg;

  localparam int VAL_W     = 48;
  localparam int IN_VAL_W  = 32;
  localparam int CODE_W    = 6;
  localparam int SLOT_W    = 6;
  localparam int USED_W    = 7;
  localparam int CNT_W     = 5;
  localparam int CLAMP_W   = 27;
  localparam int MAG_W     = 26;
  localparam int FRAC_BITS = 16;
  localparam int OP_CODES  = 4;
  localparam int PROD_W    = 2 * CLAMP_W;
  localparam int DIVD_W    = MAG_W + FRAC_BITS;
  // operator stack entry: held flag, operator, clamped left operand
  localparam int STK_W     = 1 + 2 + CLAMP_W;

  localparam logic signed [CLAMP_W-1:0] CLAMP_HI = 27'sd65536000;
  localparam logic signed [CLAMP_W-1:0] CLAMP_LO = -27'sd65536000;

  localparam logic CFG_CONST_COUNT = 1'b0;
  localparam logic CFG_FEAT_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NODE  = 2'd0,
    CMD_CONST = 2'd1,
    CMD_FEAT  = 2'd2,
    CMD_EVAL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_RUN  = 2'd1,
    ERR_FEAT = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_NODE,
    BK_LEAF,
    BK_UNWIND,
    BK_TOP,
    BK_MUL,
    BK_DIV
  } bk_state_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [SLOT_W-1:0]           slot;
    logic [CODE_W-1:0]           node_code;
    logic signed [IN_VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic [USED_W-1:0]       nodes_used;
    err_t                    error;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  function automatic logic signed [CLAMP_W-1:0] clamp_q16(input logic signed [VAL_W-1:0] v);
    logic signed [CLAMP_W-1:0] r;
    if (v < VAL_W'(CLAMP_LO)) r = CLAMP_LO;
    else if (v > VAL_W'(CLAMP_HI)) r = CLAMP_HI;
    else r = v[CLAMP_W-1:0];
    return r;
  endfunction

endpackage

### src/prefix_tree_expression_eval.sv
// Prefix-order expression tree evaluator.
// Input: one transaction is taken at each clock edge with start high and busy
// low. cmd selects a node, constant or feature store write (slot, node_code,
// value) or an evaluate. Transactions enter a two-entry queue; busy is high
// while that queue is full.
// Loads retire one per cycle while no evaluate is running and produce no
// result. An evaluate walks the program from node 0: it fetches and decodes
// each node, reads each leaf, parks each operator's left operand on the
// operator stack and reduces each operator, with an extra step for a multiply
// and a serial restoring divider for a divide (one quotient bit per cycle).
// Output: out_valid strobes for one cycle with out_item (result, nodes_used,
// error); the receiver cannot stall, so nothing is held back.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (constant
// count, feature count), saturated to [1, store size]; write only when idle.
// Reset clears the queue, the sequencer and both counts to 1; store contents
// are undefined until loaded.
module prefix_tree_expression_eval #(
  parameter int MAX_NODES     = 64,
  parameter int MAX_CONSTANTS = 16,
  parameter int MAX_FEATURES  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ptee_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output ptee_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ptee_pkg::CNT_W-1:0] cfg_wdata
);
  import ptee_pkg::*;

  logic [CNT_W-1:0] const_count_r, feat_count_r;
  q_head_t          head;
  logic             pop, full;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v, input int top);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (int'(v) > top) r = CNT_W'(top);
    else r = v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_count_r <= CNT_W'(1);
      feat_count_r  <= CNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == CFG_CONST_COUNT) const_count_r <= sat_count(cfg_wdata, MAX_CONSTANTS);
      if (cfg_index == CFG_FEAT_COUNT)  feat_count_r  <= sat_count(cfg_wdata, MAX_FEATURES);
    end
  end

  assign busy = full;

  ptee_fifo u_front (
    .clk, .rst_n, .push(start && !full), .push_item(in_item), .full(full),
    .pop(pop), .head(head)
  );

  ptee_back #(
    .MAX_NODES(MAX_NODES), .MAX_CONSTANTS(MAX_CONSTANTS), .MAX_FEATURES(MAX_FEATURES)
  ) u_back (
    .clk, .rst_n, .head(head), .pop(pop), .const_count(const_count_r),
    .feat_count(feat_count_r), .out_valid(out_valid), .out_item(out_item)
  );
endmodule

### src/ptee_ram.sv
module ptee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/ptee_fifo.sv
module ptee_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptee_pkg::in_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output ptee_pkg::q_head_t   head
);
  import ptee_pkg::*;

  in_item_t   slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### src/ptee_div.sv
module ptee_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ptee_pkg::DIVD_W-1:0]   dividend,
  input  logic [ptee_pkg::MAG_W-1:0]    divisor,
  output logic                          done,
  output logic [ptee_pkg::DIVD_W-1:0]   quotient
);
  import ptee_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] q_r;
  logic [MAG_W:0]    rem_r;
  logic [MAG_W-1:0]  d_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [MAG_W:0]    rem_sh;
  logic              fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r[MAG_W-1:0], q_r[DIVD_W-1]};
  assign fits     = (rem_sh >= {1'b0, d_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVD_W-2:0], fits};
      rem_r <= fits ? (rem_sh - {1'b0, d_r}) : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

### src/ptee_back.sv
module ptee_back #(
  parameter int MAX_NODES     = 64,
  parameter int MAX_CONSTANTS = 16,
  parameter int MAX_FEATURES  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptee_pkg::q_head_t          head,
  output logic                       pop,
  input  logic [ptee_pkg::CNT_W-1:0] const_count,
  input  logic [ptee_pkg::CNT_W-1:0] feat_count,
  output logic                       out_valid,
  output ptee_pkg::out_item_t        out_item
);
  import ptee_pkg::*;

  localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW  = $clog2(MAX_NODES + 1);
  localparam int CAW = (MAX_CONSTANTS > 1) ? $clog2(MAX_CONSTANTS) : 1;
  localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  bk_state_t state_r, state_nxt;

  logic [PW-1:0]            pos_r, pos_nxt;
  logic [PW-1:0]            depth_r, depth_nxt;
  logic signed [VAL_W-1:0]  v_r, v_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic                     leaf_feat_r, leaf_feat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic              prog_we;
  logic [AW-1:0]     prog_waddr, prog_raddr;
  logic [CODE_W-1:0] prog_rdata;
  logic              const_we, feat_we;
  logic [CAW-1:0]    const_waddr, const_raddr;
  logic [FAW-1:0]    feat_waddr, feat_raddr;
  logic [IN_VAL_W-1:0] const_rdata, feat_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_rdata;

  logic                     div_start, div_done;
  logic [DIVD_W-1:0]        div_q;
  logic [MAG_W-1:0]         mag_a, mag_b;

  logic [USED_W-1:0]        node7, feat_idx;
  logic                     is_op, is_const, feat_ok, run_past, top_held;
  op_t                      top_op;
  logic signed [CLAMP_W-1:0] top_a, b_cl;
  logic signed [PROD_W-1:0]  prod_adj;

  ptee_ram #(.WIDTH(CODE_W), .DEPTH(MAX_NODES)) u_prog (
    .clk, .we(prog_we), .waddr(prog_waddr), .wdata(head.item.node_code),
    .raddr(prog_raddr), .rdata(prog_rdata)
  );
  ptee_ram #(.WIDTH(IN_VAL_W), .DEPTH(MAX_CONSTANTS)) u_const (
    .clk, .we(const_we), .waddr(const_waddr), .wdata(head.item.value),
    .raddr(const_raddr), .rdata(const_rdata)
  );
  ptee_ram #(.WIDTH(IN_VAL_W), .DEPTH(MAX_FEATURES)) u_feat (
    .clk, .we(feat_we), .waddr(feat_waddr), .wdata(head.item.value),
    .raddr(feat_raddr), .rdata(feat_rdata)
  );
  ptee_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );
  ptee_div u_div (
    .clk, .rst_n, .start(div_start), .dividend({mag_a, {FRAC_BITS{1'b0}}}),
    .divisor(mag_b), .done(div_done), .quotient(div_q)
  );

  assign node7    = {1'b0, prog_rdata};
  assign is_op    = (node7 < USED_W'(OP_CODES));
  assign is_const = (node7 < USED_W'(OP_CODES) + USED_W'(const_count));
  assign feat_idx = node7 - USED_W'(OP_CODES) - USED_W'(const_count);
  assign feat_ok  = (feat_idx < USED_W'(feat_count));
  assign run_past = (int'(pos_r) >= MAX_NODES);
  assign top_held = stk_rdata[STK_W-1];
  assign top_op   = op_t'(stk_rdata[STK_W-2 -: 2]);
  assign top_a    = stk_rdata[CLAMP_W-1:0];
  assign b_cl     = clamp_q16(v_r);
  assign mag_a    = top_a[CLAMP_W-1] ? MAG_W'(-top_a) : MAG_W'(top_a);
  assign mag_b    = b_cl[CLAMP_W-1] ? MAG_W'(-b_cl) : MAG_W'(b_cl);
  // toward-zero truncation of the product scale-down
  assign prod_adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (head.valid && head.item.cmd == CMD_EVAL) state_nxt = BK_FETCH;
      BK_FETCH:  state_nxt = run_past ? BK_IDLE : BK_NODE;
      BK_NODE: begin
        if (is_op) state_nxt = BK_FETCH;
        else if (is_const || feat_ok) state_nxt = BK_LEAF;
        else state_nxt = BK_IDLE;
      end
      BK_LEAF:   state_nxt = BK_UNWIND;
      BK_UNWIND: state_nxt = (depth_r == '0) ? BK_IDLE : BK_TOP;
      BK_TOP: begin
        if (!top_held) state_nxt = BK_FETCH;
        else if (top_op == OP_MUL) state_nxt = BK_MUL;
        else if (top_op == OP_DIV && b_cl != '0) state_nxt = BK_DIV;
        else state_nxt = BK_UNWIND;
      end
      BK_MUL:    state_nxt = BK_UNWIND;
      BK_DIV:    if (div_done) state_nxt = BK_UNWIND;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    depth_nxt     = depth_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    leaf_feat_nxt = leaf_feat_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    prog_we       = 1'b0;
    const_we      = 1'b0;
    feat_we       = 1'b0;
    prog_waddr    = AW'(head.item.slot);
    const_waddr   = CAW'(head.item.slot);
    feat_waddr    = FAW'(head.item.slot);
    prog_raddr    = AW'(pos_r);
    const_raddr   = CAW'(node7 - USED_W'(OP_CODES));
    feat_raddr    = FAW'(feat_idx);
    stk_we        = 1'b0;
    stk_waddr     = AW'(depth_r);
    stk_wdata     = {1'b0, prog_rdata[1:0], {CLAMP_W{1'b0}}};
    stk_raddr     = AW'(depth_r - 1'b1);
    div_start     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.cmd)
            CMD_NODE:  prog_we  = (int'(head.item.slot) < MAX_NODES);
            CMD_CONST: const_we = (int'(head.item.slot) < MAX_CONSTANTS);
            CMD_FEAT:  feat_we  = (int'(head.item.slot) < MAX_FEATURES);
            default: begin
              pos_nxt   = '0;
              depth_nxt = '0;
            end
          endcase
        end
      end
      BK_FETCH: begin
        if (run_past) begin
          out_valid_nxt      = 1'b1;
          out_nxt.result     = '0;
          out_nxt.nodes_used = USED_W'(pos_r);
          out_nxt.error      = ERR_RUN;
        end
      end
      BK_NODE: begin
        pos_nxt = pos_r + 1'b1;
        if (is_op) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end else if (is_const) begin
          leaf_feat_nxt = 1'b0;
        end else if (feat_ok) begin
          leaf_feat_nxt = 1'b1;
        end else begin
          out_valid_nxt      = 1'b1;
          out_nxt.result     = '0;
          out_nxt.nodes_used = USED_W'(pos_r + 1'b1);
          out_nxt.error      = ERR_FEAT;
        end
      end
      BK_LEAF: begin
        v_nxt = VAL_W'(signed'(leaf_feat_r ? feat_rdata : const_rdata));
      end
      BK_UNWIND: begin
        if (depth_r == '0) begin
          out_valid_nxt      = 1'b1;
          out_nxt.result     = v_r;
          out_nxt.nodes_used = USED_W'(pos_r);
          out_nxt.error      = ERR_NONE;
        end
      end
      BK_TOP: begin
        if (!top_held) begin
          stk_we    = 1'b1;
          stk_waddr = AW'(depth_r - 1'b1);
          stk_wdata = {1'b1, top_op, b_cl};
        end else begin
          case (top_op)
            OP_ADD: begin
              v_nxt     = VAL_W'(top_a) + VAL_W'(b_cl);
              depth_nxt = depth_r - 1'b1;
            end
            OP_SUB: begin
              v_nxt     = VAL_W'(top_a) - VAL_W'(b_cl);
              depth_nxt = depth_r - 1'b1;
            end
            OP_MUL: begin
              prod_nxt = PROD_W'(top_a) * PROD_W'(b_cl);
            end
            default: begin
              if (b_cl == '0) begin
                v_nxt     = VAL_W'(top_a);
                depth_nxt = depth_r - 1'b1;
              end else begin
                div_start = 1'b1;
                neg_nxt   = top_a[CLAMP_W-1] ^ b_cl[CLAMP_W-1];
              end
            end
          endcase
        end
      end
      BK_MUL: begin
        v_nxt     = VAL_W'(prod_adj >>> FRAC_BITS);
        depth_nxt = depth_r - 1'b1;
      end
      BK_DIV: begin
        if (div_done) begin
          v_nxt     = neg_r ? -VAL_W'(div_q) : VAL_W'(div_q);
          depth_nxt = depth_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    v_r         <= v_nxt;
    prod_r      <= prod_nxt;
    neg_r       <= neg_nxt;
    leaf_feat_r <= leaf_feat_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("back-to-back result strobes");
  a_div_resume: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && div_done) |=> state_r == BK_UNWIND)
    else $error("divide completion lost");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(depth_r) <= MAX_NODES) else $error("operator stack overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE) else $error("queue popped while busy");
endmodule

### bench/tb_prefix_tree_expression_eval.sv
`timescale 1ns / 1ps

module tb_prefix_tree_expression_eval;
  import ptee_pkg::*;

  localparam int NODES = 64;
  localparam int CONSTS = 16;
  localparam int FEATS = 16;
  localparam longint Q_ONE = 65536;
  localparam longint LIM_HI = 1000 * Q_ONE;
  localparam longint LIM_LO = -1000 * Q_ONE;
  localparam int SETTLE = 20;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_CONST_COUNT;
  logic [CNT_W-1:0] cfg_wdata = '0;

  prefix_tree_expression_eval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the block's stores and counts
  logic [CODE_W-1:0] prog_mem [NODES];
  longint const_mem [CONSTS];
  longint feat_mem [FEATS];
  int n_const = 1;
  int n_feat = 1;

  out_item_t pending_results [$];
  int errors = 0;
  int idle_pct = 0;
  longint cycles = 0;

  typedef struct {
    cmd_t cmd;
    int slot;
    int code;
    logic [31:0] val;
    bit has_exp;
    out_item_t exp;
  } row_t;
  row_t rows [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_item);
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_item.result !== e.result || out_item.nodes_used !== e.nodes_used ||
            out_item.error !== e.error) begin
          errors++;
          $display("%0t mismatch: expected res=%h used=%0d err=%0d, got res=%h used=%0d err=%0d",
                   $time, e.result, e.nodes_used, e.error,
                   out_item.result, out_item.nodes_used, out_item.error);
        end
      end
    end
  end

  function automatic longint limit_q16(longint v);
    if (v < LIM_LO) return LIM_LO;
    if (v > LIM_HI) return LIM_HI;
    return v;
  endfunction

  function automatic longint arith(logic [1:0] op, longint a, longint b);
    case (op_t'(op))
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return (a * b) / Q_ONE;
      default: return (b != 0) ? (a * Q_ONE) / b : a;
    endcase
  endfunction

  // walk the shadow program in prefix order
  function automatic out_item_t eval_tree();
    logic [1:0] pend [NODES];
    bit held [NODES];
    longint lhs [NODES];
    longint v;
    int pos;
    int depth;
    int node;
    int f;
    err_t e;
    out_item_t o;
    v = 0;
    pos = 0;
    depth = 0;
    e = ERR_NONE;
    forever begin
      if (pos >= NODES) begin
        e = ERR_RUN;
        break;
      end
      node = prog_mem[pos];
      pos++;
      if (node < OP_CODES) begin
        pend[depth] = node[1:0];
        held[depth] = 1'b0;
        depth++;
        continue;
      end
      if (node < OP_CODES + n_const) begin
        v = const_mem[node - OP_CODES];
      end else begin
        f = node - OP_CODES - n_const;
        if (f >= n_feat) begin
          e = ERR_FEAT;
          break;
        end
        v = feat_mem[f];
      end
      while (depth > 0) begin
        if (!held[depth-1]) begin
          lhs[depth-1] = limit_q16(v);
          held[depth-1] = 1'b1;
          break;
        end
        v = arith(pend[depth-1], lhs[depth-1], limit_q16(v));
        depth--;
      end
      if (depth == 0) break;
    end
    o.result = (e != ERR_NONE) ? '0 : v[VAL_W-1:0];
    o.nodes_used = pos[USED_W-1:0];
    o.error = e;
    return o;
  endfunction

  task automatic send(cmd_t cmd, int slot, int code, logic [31:0] val,
                      bit has_exp = 1'b0, out_item_t exp = '0);
    in_item_t it;
    it.cmd = cmd;
    it.slot = slot[SLOT_W-1:0];
    it.node_code = code[CODE_W-1:0];
    it.value = val;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    case (cmd)
      CMD_NODE: prog_mem[it.slot] = it.node_code;
      CMD_CONST: if (it.slot < CONSTS) const_mem[it.slot] = longint'(it.value);
      CMD_FEAT: if (it.slot < FEATS) feat_mem[it.slot] = longint'(it.value);
      default: pending_results.push_back(has_exp ? exp : eval_tree());
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_count(logic idx, int wval);
    int sat;
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = wval[CNT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sat = (wval < 1) ? 1 : wval;
    if (idx == CFG_CONST_COUNT) n_const = (sat > CONSTS) ? CONSTS : sat;
    else n_feat = (sat > FEATS) ? FEATS : sat;
  endtask

  function automatic logic [31:0] rand_q16();
    int r;
    r = $urandom_range(99);
    if (r < 25) return $urandom;
    if (r < 32) return 32'd0;
    return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
  endfunction

  task automatic add_row(cmd_t cmd, int slot, int code, logic [31:0] val,
                         bit has_exp = 1'b0, out_item_t exp = '0);
    row_t r;
    r.cmd = cmd;
    r.slot = slot;
    r.code = code;
    r.val = val;
    r.has_exp = has_exp;
    r.exp = exp;
    rows.push_back(r);
  endtask

  // one random program, not always well-formed, plus up to three operand loads, then evaluate
  task automatic random_program(output int n_sent);
    int codes [NODES];
    int len;
    int need;
    int op_pct;
    int r;
    int n_ld;
    len = 0;
    need = 1;
    op_pct = ($urandom_range(99) < 5) ? 92 : 0;
    while (need > 0 && len < NODES) begin
      r = $urandom_range(99);
      if (r < (op_pct != 0 ? op_pct : (len < 6 ? 50 : 30))) begin
        codes[len] = $urandom_range(OP_ADD, OP_DIV);
        need++;
      end else begin
        r = $urandom_range(99);
        if (r < 45) codes[len] = OP_CODES + $urandom_range(n_const - 1);
        else if (r < 92) codes[len] = OP_CODES + n_const + $urandom_range(n_feat - 1);
        else codes[len] = $urandom_range(OP_CODES, 63);
        need--;
      end
      len++;
    end
    for (int i = 0; i < len; i++) send(CMD_NODE, i, codes[i], $urandom);
    n_ld = $urandom_range(0, 3);
    repeat (n_ld) begin
      if ($urandom_range(1)) send(CMD_CONST, $urandom_range(n_const - 1), $urandom, rand_q16());
      else send(CMD_FEAT, $urandom_range(n_feat - 1), $urandom, rand_q16());
    end
    send(CMD_EVAL, $urandom, $urandom, $urandom);
    n_sent = len + n_ld + 1;
  endtask

  task automatic random_phase(int items);
    int sent;
    int k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 85) begin
        random_program(k);
        sent += k;
      end else begin
        send(cmd_t'($urandom_range(CMD_NODE, CMD_EVAL)), $urandom_range(63),
             $urandom_range(63), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    row_t r;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every store entry gets written before any evaluate
    for (int i = 0; i < NODES; i++) send(CMD_NODE, i, OP_ADD, 32'd0);
    for (int i = 0; i < CONSTS; i++) send(CMD_CONST, i, 0, rand_q16());
    for (int i = 0; i < FEATS; i++) send(CMD_FEAT, i, 0, rand_q16());

    // all operators: walk runs off the end of the node store
    add_row(CMD_EVAL, 0, 0, 0, 1, '{result: '0, nodes_used: 7'd64, error: ERR_RUN});
    add_row(CMD_CONST, 0, 0, 32'h7FFF_FFFF);
    add_row(CMD_NODE, 0, OP_CODES, 0);
    add_row(CMD_EVAL, 0, 0, 0, 1,
            '{result: 48'sh0000_7FFF_FFFF, nodes_used: 7'd1, error: ERR_NONE});
    add_row(CMD_CONST, 0, 0, 32'h8000_0000);
    add_row(CMD_EVAL, 63, 63, 32'hFFFF_FFFF, 1,
            '{result: 48'shFFFF_8000_0000, nodes_used: 7'd1, error: ERR_NONE});
    add_row(CMD_NODE, 0, OP_CODES + 2, 0);
    add_row(CMD_EVAL, 0, 0, 0, 1, '{result: '0, nodes_used: 7'd1, error: ERR_FEAT});
    add_row(CMD_NODE, 0, 63, 0);
    add_row(CMD_EVAL, 0, 0, 0, 1, '{result: '0, nodes_used: 7'd1, error: ERR_FEAT});
    add_row(CMD_CONST, 0, 0, 32'h0003_0000);
    add_row(CMD_FEAT, 0, 0, 32'h0002_0000);
    add_row(CMD_NODE, 1, OP_CODES, 0);
    add_row(CMD_NODE, 2, OP_CODES + 1, 0);
    add_row(CMD_NODE, 0, OP_ADD, 0);
    add_row(CMD_EVAL, 0, 0, 0);
    add_row(CMD_NODE, 0, OP_SUB, 0);
    add_row(CMD_EVAL, 0, 0, 0);
    add_row(CMD_NODE, 0, OP_MUL, 0);
    add_row(CMD_EVAL, 0, 0, 0);
    add_row(CMD_NODE, 0, OP_DIV, 0);
    add_row(CMD_EVAL, 0, 0, 0);
    // protected divide returns the left operand
    add_row(CMD_FEAT, 0, 0, 32'd0);
    add_row(CMD_EVAL, 0, 0, 0, 1,
            '{result: 48'sh0000_0003_0000, nodes_used: 7'd3, error: ERR_NONE});
    add_row(CMD_CONST, 0, 0, 32'h7FFF_FFFF);
    add_row(CMD_NODE, 0, OP_ADD, 0);
    add_row(CMD_EVAL, 0, 0, 0, 1,
            '{result: 48'sh0000_03E8_0000, nodes_used: 7'd3, error: ERR_NONE});
    // slots past the operand stores are dropped
    add_row(CMD_CONST, 20, 0, 32'h1234_5678);
    add_row(CMD_FEAT, 63, 0, 32'h1234_5678);
    add_row(CMD_EVAL, 0, 0, 0);

    foreach (rows[i]) begin
      r = rows[i];
      send(r.cmd, r.slot, r.code, r.val, r.has_exp, r.exp);
    end

    write_count(CFG_CONST_COUNT, 0);
    write_count(CFG_FEAT_COUNT, 31);
    idle_pct = 25;
    random_phase(500);

    write_count(CFG_CONST_COUNT, 16);
    write_count(CFG_FEAT_COUNT, 1);
    idle_pct = 62;
    random_phase(500);

    write_count(CFG_CONST_COUNT, 31);
    write_count(CFG_FEAT_COUNT, $urandom_range(2, 15));
    idle_pct = 0;
    random_phase(250);

    write_count(CFG_CONST_COUNT, $urandom_range(2, 15));
    write_count(CFG_FEAT_COUNT, 16);
    random_phase(250);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
src/ptee_pkg.sv
src/ptee_ram.sv
src/ptee_fifo.sv
src/ptee_div.sv
src/ptee_back.sv
src/prefix_tree_expression_eval.sv
bench/tb_prefix_tree_expression_eval.sv
